// ===== rtl/i2f_pkg.sv =====
// ----------------------------------------------------------------------------
// i2f_pkg: shared types and constants of the integer to float converter
// Field widths, IEEE single layout constants and the stage payload structs.
// ----------------------------------------------------------------------------
package i2f_pkg;

  localparam int unsigned IntWidth   = 32;
  localparam int unsigned FloatWidth = 32;
  localparam int unsigned ExpWidth   = 8;
  localparam int unsigned FracWidth  = 23;
  localparam int unsigned PosWidth   = $clog2(IntWidth);

  localparam logic [ExpWidth-1:0] ExpBias = 8'h7F;

  typedef struct packed {
    logic                sign;
    logic                zero;
    logic [IntWidth-1:0] mag;
  } sgnmag_t;

  typedef struct packed {
    logic                sign;
    logic                zero;
    logic [ExpWidth-1:0] expo;
    logic [IntWidth-1:0] mant;
  } norm_t;

endpackage

// ===== rtl/i2f_in_if.sv =====
// ----------------------------------------------------------------------------
// i2f_in_if: input channel of the converter
// Valid/ready channel carrying one signed integer per beat.
// ----------------------------------------------------------------------------
interface i2f_in_if
  import i2f_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [IntWidth-1:0] int_value;

  modport source (output valid, output int_value, input ready);
  modport sink   (input valid, input int_value, output ready);
endinterface

// ===== rtl/i2f_out_if.sv =====
// ----------------------------------------------------------------------------
// i2f_out_if: output channel of the converter
// Valid/ready channel carrying one IEEE single bit pattern per beat.
// ----------------------------------------------------------------------------
interface i2f_out_if
  import i2f_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [FloatWidth-1:0] float_word;

  modport source (output valid, output float_word, input ready);
  modport sink   (input valid, input float_word, output ready);
endinterface

// ===== rtl/i2f_sgnmag.sv =====
// ----------------------------------------------------------------------------
// i2f_sgnmag: sign and magnitude stage
// Splits the two's complement input into sign, zero flag and magnitude.
// ----------------------------------------------------------------------------
module i2f_sgnmag
  import i2f_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [IntWidth-1:0] int_value_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output sgnmag_t                    data_o
);

  logic    valid_q;
  sgnmag_t data_d, data_q;

  always_comb begin
    data_d.sign = int_value_i[IntWidth-1];
    data_d.zero = (int_value_i == '0);
    data_d.mag  = data_d.sign ? (~int_value_i + 1'b1) : int_value_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/i2f_norm.sv =====
// ----------------------------------------------------------------------------
// i2f_norm: normalize stage
// Finds the leading one, forms the biased exponent and left-aligns the
// magnitude so that its leading one sits in the top bit.
// ----------------------------------------------------------------------------
module i2f_norm
  import i2f_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  sgnmag_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output norm_t   data_o
);

  logic                valid_q;
  norm_t               data_d, data_q;
  logic [PosWidth-1:0] lead;
  logic [PosWidth-1:0] shamt;

  always_comb begin
    lead = '0;
    for (int i = 0; i < IntWidth; i++) begin
      if (data_i.mag[i]) begin
        lead = PosWidth'(i);
      end
    end
    shamt       = PosWidth'(IntWidth - 1) - lead;
    data_d.sign = data_i.sign;
    data_d.zero = data_i.zero;
    data_d.expo = ExpBias + ExpWidth'(lead);
    data_d.mant = data_i.mag << shamt;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/i2f_round.sv =====
// ----------------------------------------------------------------------------
// i2f_round: round and pack stage
// Rounds the aligned mantissa to nearest, ties to even, lets the carry
// ripple into the exponent and packs the IEEE single word.
// ----------------------------------------------------------------------------
module i2f_round
  import i2f_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  norm_t                 data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [FloatWidth-1:0] float_word_o
);

  localparam int unsigned DropBits = IntWidth - FracWidth - 1;

  logic                            valid_q;
  logic [FloatWidth-1:0]           word_d, word_q;
  logic [FracWidth-1:0]            frac;
  logic                            guard;
  logic                            sticky;
  logic                            round_up;
  logic [ExpWidth+FracWidth-1:0]   body;

  always_comb begin
    frac     = data_i.mant[IntWidth-2 -: FracWidth];
    guard    = data_i.mant[DropBits-1];
    sticky   = |data_i.mant[DropBits-2:0];
    round_up = guard && (sticky || frac[0]);
    body     = {data_i.expo, frac} + (ExpWidth+FracWidth)'(round_up);
    word_d   = data_i.zero ? '0 : {data_i.sign, body};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o      = valid_q;
  assign float_word_o = word_q;

endmodule

// ===== rtl/int32_to_float32_converter.sv =====
// ----------------------------------------------------------------------------
// int32_to_float32_converter: signed 32-bit integer to IEEE single precision
// Converts each input beat to the nearest single-precision value, rounding
// to nearest with ties to even. Zero gives positive zero; the most negative
// integer gives 0xCF000000. There are three register stages (sign/magnitude,
// leading one detect and normalize, round and pack), and the block takes one
// beat every cycle while the output is not stalled.
// Each stage holds its own valid bit and ready, so a stall at the output
// backs up stage by stage without losing or repeating a beat.
// ----------------------------------------------------------------------------
module int32_to_float32_converter
  import i2f_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  i2f_in_if.sink    in_i,
  i2f_out_if.source out_o
);

  logic    s1_valid, s1_ready;
  sgnmag_t s1_data;
  logic    s2_valid, s2_ready;
  norm_t   s2_data;

  i2f_sgnmag u_sgnmag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .int_value_i (in_i.int_value),
    .valid_o     (s1_valid),
    .ready_i     (s1_ready),
    .data_o      (s1_data)
  );

  i2f_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  i2f_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s2_valid),
    .ready_o      (s2_ready),
    .data_i       (s2_data),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .float_word_o (out_o.float_word)
  );

endmodule
